// ===== hw/rtl/lps_pkg.sv =====
package lps_pkg;

   // Field widths of the request and response payloads.
   localparam int DIGIT_W     = 4;
   localparam int PERM_W      = 40;
   localparam int PERM_MAX_W  = 48;
   localparam int RANK_W      = 22;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_PAD_W   = RSP_TDATA_W - PERM_W - RANK_W;

   localparam logic [RANK_W-1:0] TARGET_RESET = RANK_W'(1000000);

   typedef enum logic [12:0] {
      S_FILL     = 13'b0000000000001,
      S_IDLE     = 13'b0000000000010,
      S_CAPTURE  = 13'b0000000000100,
      S_SCAN_RD  = 13'b0000000001000,
      S_SCAN_CMP = 13'b0000000010000,
      S_FIND_RD  = 13'b0000000100000,
      S_FIND_CMP = 13'b0000001000000,
      S_SWAP_LO  = 13'b0000010000000,
      S_SWAP_HI  = 13'b0000100000000,
      S_REV_RD   = 13'b0001000000000,
      S_REV_LO   = 13'b0010000000000,
      S_REV_HI   = 13'b0100000000000,
      S_OUT      = 13'b1000000000000
   } state_type;

endpackage

// ===== hw/rtl/lps_ram.sv =====
module lps_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Both read ports return the contents from before a write at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== hw/rtl/lexicographic_permutation_stepper_top.sv =====
// Lexicographic permutation stepper. Each request moves through the permutations of the
// digits 0 to DIGITS-1 in lexicographic order and returns one response: the current
// permutation (four bits per digit, first digit in the highest used nibble, cut to 40
// bits), its 1-based rank, a flag in tuser when that rank equals the target register and
// tlast once the final, descending permutation has been reached, after which the same
// response is repeated. A request with restart set returns to the ascending permutation,
// which it reports as rank 1. The digits live in a small two-read-port RAM and one shared
// magnitude comparator drives the next-permutation rule. Once the last permutation has
// been reached a request only reports it again, and in half of all steps only the last
// two digits change. The longest step comes when the pivot is the first digit and both
// the successor search and the reversal run over the whole suffix: each scanned position
// is read and then compared, the swap writes the low side and then the high side, and
// each pair of reversed digits is read, then written low and then high, as the RAM has a
// single write port. A restart first reloads the RAM with the ascending permutation, and
// after reset the same reload runs before the first request is taken. A finished response
// waits in its own register, so the next request is accepted while the previous response
// is still pending.
module lexicographic_permutation_stepper_top #(
   parameter int DIGITS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lps_pkg::RANK_W-1:0]       csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lps_pkg::REQ_TDATA_W-1:0]  req_tdata,   // [0] restart, rest zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,   // [39:0] perm_digits, [61:40] rank
   output logic                             rsp_tuser,   // [0] is_target
   output logic                             rsp_tlast    // is_last
);

   import lps_pkg::*;

   localparam int IDX_W  = $clog2(DIGITS);
   localparam int PACK_W = DIGIT_W * DIGITS;

   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DIGITS - 1);
   localparam logic [IDX_W-1:0] PenIdx  = IDX_W'(DIGITS - 2);

   // Sequencer state and control registers.
   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     i_ff, i_in;          // fill counter, pivot position, low end of reversal
   logic [IDX_W-1:0]     j_ff, j_in;          // successor position, high end of reversal
   logic [RANK_W-1:0]    count_ff, count_in;
   logic                 exhausted_ff, exhausted_in;
   logic                 restart_ff, restart_in;
   logic [RANK_W-1:0]    target_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [DIGIT_W-1:0]   piv_ff, piv_in;
   logic [DIGIT_W-1:0]   hold_ff, hold_in;
   logic [PERM_W-1:0]    perm_ff, perm_in;
   logic [PERM_W-1:0]    rsp_perm_ff;
   logic [RANK_W-1:0]    rsp_rank_ff;
   logic                 rsp_target_ff;
   logic                 rsp_last_ff;
   logic [DIGIT_W-1:0]   mirror_ff [DIGITS];

   // RAM ports.
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DIGIT_W-1:0]   wr_data;
   logic [IDX_W-1:0]     rd_addr_a;
   logic [IDX_W-1:0]     rd_addr_b;
   logic [DIGIT_W-1:0]   rd_a;
   logic [DIGIT_W-1:0]   rd_b;

   // Shared comparator and index arithmetic.
   logic [DIGIT_W-1:0]   cmp_x;
   logic                 cmp_lt;
   logic [IDX_W:0]       lo_nx;
   logic [IDX_W:0]       hi_nx;

   logic [PACK_W-1:0]     packed_perm;
   logic [PERM_MAX_W-1:0] wide_perm;
   logic                  rsp_load;

   lps_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DIGITS)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_b)
   );

   // Port A always follows the low index. Port B reads the right-hand neighbour during
   // the pivot scan and the high index otherwise.
   assign rd_addr_a = i_ff;
   assign rd_addr_b = (state_ff == S_SCAN_RD || state_ff == S_SCAN_CMP)
                      ? IDX_W'({1'b0, i_ff} + 1'b1) : j_ff;

   // The one digit comparison of the design: an ascent during the scan, and a digit larger
   // than the pivot during the successor search. The right operand is always port B.
   assign cmp_x  = (state_ff == S_SCAN_CMP) ? rd_a : piv_ff;
   assign cmp_lt = cmp_x < rd_b;

   assign lo_nx = {1'b0, i_ff} + 1'b1;
   assign hi_nx = {1'b0, j_ff} - 1'b1;

   // The low side of a swap or reversal and the reload counter write at i; the high
   // side writes at j.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = i_ff;
      wr_data = DIGIT_W'(i_ff);
      case (state_ff)
         S_FILL: begin
            wr_en = 1'b1;
         end
         S_SWAP_LO: begin
            wr_en   = 1'b1;
            wr_data = hold_ff;
         end
         S_SWAP_HI: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = piv_ff;
         end
         S_REV_LO: begin
            wr_en   = 1'b1;
            wr_data = rd_b;
         end
         S_REV_HI: begin
            wr_en   = 1'b1;
            wr_addr = j_ff;
            wr_data = hold_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // A copy of the RAM contents kept in flip-flops, so that the whole permutation can be
   // captured at once when a step begins.
   always_comb begin
      for (int k = 0; k < DIGITS; k++) begin
         packed_perm[DIGIT_W*(DIGITS-1-k) +: DIGIT_W] = mirror_ff[k];
      end
   end

   assign wide_perm = PERM_MAX_W'(packed_perm);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      count_in     = count_ff;
      exhausted_in = exhausted_ff;
      restart_in   = restart_ff;
      piv_in       = piv_ff;
      hold_in      = hold_ff;
      perm_in      = perm_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_FILL: begin
            // Reload the ascending permutation, one digit per cycle.
            if (i_ff == LastIdx) begin
               state_in = restart_ff ? S_CAPTURE : S_IDLE;
            end else begin
               i_in = IDX_W'(lo_nx);
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               restart_in = req_tdata[0];
               if (req_tdata[0]) begin
                  i_in         = '0;
                  count_in     = '0;
                  exhausted_in = 1'b0;
                  state_in     = S_FILL;
               end else begin
                  state_in = S_CAPTURE;
               end
            end
         end
         S_CAPTURE: begin
            perm_in = wide_perm[PERM_W-1:0];
            if (exhausted_ff) begin
               state_in = S_OUT;
            end else begin
               count_in = count_ff + 1'b1;
               i_in     = PenIdx;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (cmp_lt) begin
               piv_in   = rd_a;
               j_in     = LastIdx;
               state_in = S_FIND_RD;
            end else if (i_ff == '0) begin
               // No ascent anywhere: this was the descending permutation.
               exhausted_in = 1'b1;
               state_in     = S_OUT;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_FIND_RD: begin
            state_in = S_FIND_CMP;
         end
         S_FIND_CMP: begin
            if (cmp_lt) begin
               hold_in  = rd_b;
               state_in = S_SWAP_LO;
            end else begin
               j_in     = IDX_W'(hi_nx);
               state_in = S_FIND_RD;
            end
         end
         S_SWAP_LO: begin
            state_in = S_SWAP_HI;
         end
         S_SWAP_HI: begin
            i_in = IDX_W'(lo_nx);
            j_in = LastIdx;
            if (lo_nx < {1'b0, LastIdx}) begin
               state_in = S_REV_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_REV_RD: begin
            state_in = S_REV_LO;
         end
         S_REV_LO: begin
            hold_in  = rd_a;
            state_in = S_REV_HI;
         end
         S_REV_HI: begin
            i_in = IDX_W'(lo_nx);
            j_in = IDX_W'(hi_nx);
            if (lo_nx < hi_nx) begin
               state_in = S_REV_RD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers. Reset starts the reload of the ascending permutation.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_FILL;
         i_ff         <= '0;
         count_ff     <= '0;
         exhausted_ff <= 1'b0;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= TARGET_RESET;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         count_ff     <= count_in;
         exhausted_ff <= exhausted_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      piv_ff  <= piv_in;
      hold_ff <= hold_in;
      perm_ff <= perm_in;
      if (wr_en) begin
         mirror_ff[wr_addr] <= wr_data;
      end
      if (rsp_load) begin
         rsp_perm_ff   <= perm_ff;
         rsp_rank_ff   <= count_ff;
         rsp_target_ff <= (count_ff == target_ff);
         rsp_last_ff   <= exhausted_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_rank_ff, rsp_perm_ff};
   assign rsp_tuser  = rsp_target_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/lps_checker.sv =====
module lps_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lps_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   import lps_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // The digit store is reloaded after reset before any request is taken.
   a_reload_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_tready)
      else $error("request accepted during the reload after reset");

   // One request at a time: ready drops once a request has been taken.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while a step is in progress");

   // A request first leads to the capture or reload state, so no response can appear right after it.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared one cycle after its request");

endmodule

bind lexicographic_permutation_stepper_top lps_checker u_lps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/tb.sv =====
module tb;
   import lps_pkg::*;

   // The block is built with its default ten digits, the width the response fields are
   // sized for. Runs of a hundred or so steps move the pivot well to the left.
   localparam int N_DIGITS    = 10;
   localparam int WALK_LEN    = 130;       // passes rank 121, the first pivot at the fifth digit
   localparam int RANK_TOP    = 3628800;   // highest legal target rank
   localparam int CLK_PERIOD  = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 60;

   // One expected response: the fields of rsp_tdata, rsp_tuser and rsp_tlast.
   typedef struct {
      bit [PERM_W-1:0] perm;
      bit [RANK_W-1:0] rank;
      bit              is_target;
      bit              is_last;
   } perm_result_type;

   // Tracks the stepper's state, works out the response to every accepted request and
   // compares the responses, in order, against those predictions.
   class perm_checker;
      bit [DIGIT_W-1:0] next_digits [N_DIGITS];
      bit [RANK_W-1:0]  emitted_rank;
      bit               exhausted;
      bit [RANK_W-1:0]  target_rank;
      perm_result_type  pending_perms [$];
      int unsigned      errors;

      function new();
         target_rank = TARGET_RESET;
         load_ascending();
      endfunction

      function void load_ascending();
         foreach (next_digits[k]) next_digits[k] = DIGIT_W'(k);
         emitted_rank = '0;
         exhausted    = 1'b0;
      endfunction

      function int pending();
         return pending_perms.size();
      endfunction

      function void note_request(bit restart);
         perm_result_type  res;
         bit [63:0]        packed_digits;
         bit [DIGIT_W-1:0] t;
         int               i;
         int               j;
         int               lo;
         int               hi;
         if (restart) load_ascending();
         packed_digits = '0;
         foreach (next_digits[k]) begin
            packed_digits = (packed_digits << DIGIT_W) | 64'(next_digits[k]);
         end
         if (!exhausted) begin
            emitted_rank = emitted_rank + 1'b1;
            // Rightmost ascent; none left means this was the descending permutation.
            i = N_DIGITS - 2;
            while (i >= 0 && next_digits[i] >= next_digits[i + 1]) i--;
            if (i < 0) begin
               exhausted = 1'b1;
            end else begin
               j = N_DIGITS - 1;
               while (next_digits[j] <= next_digits[i]) j--;
               t              = next_digits[i];
               next_digits[i] = next_digits[j];
               next_digits[j] = t;
               lo = i + 1;
               hi = N_DIGITS - 1;
               while (lo < hi) begin
                  t               = next_digits[lo];
                  next_digits[lo] = next_digits[hi];
                  next_digits[hi] = t;
                  lo++;
                  hi--;
               end
            end
         end
         res.perm      = packed_digits[PERM_W-1:0];
         res.rank      = emitted_rank;
         res.is_target = (emitted_rank == target_rank);
         res.is_last   = exhausted;
         pending_perms.push_back(res);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata, logic tuser, logic tlast);
         perm_result_type want;
         if (pending_perms.size() == 0) begin
            $display("%0t: response with no request outstanding, tdata %h", $time, tdata);
            errors++;
         end else begin
            want = pending_perms.pop_front();
            if (tdata[PERM_W-1:0] !== want.perm) begin
               $display("%0t: perm_digits expected %h, got %h", $time, want.perm,
                        tdata[PERM_W-1:0]);
               errors++;
            end
            if (tdata[PERM_W +: RANK_W] !== want.rank) begin
               $display("%0t: rank expected %0d, got %0d", $time, want.rank,
                        tdata[PERM_W +: RANK_W]);
               errors++;
            end
            if (tuser !== want.is_target) begin
               $display("%0t: is_target expected %b, got %b", $time, want.is_target, tuser);
               errors++;
            end
            if (tlast !== want.is_last) begin
               $display("%0t: is_last expected %b, got %b", $time, want.is_last, tlast);
               errors++;
            end
         end
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [RANK_W-1:0]      csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   // Idling controls for the two sides. hold_off_cycles asks the response side
   // for one long stall, which it counts out itself.
   bit          req_idle_on     = 1'b1;
   bit          rsp_idle_on     = 1'b1;
   int unsigned hold_off_cycles = 0;
   int unsigned cycle_count     = 0;

   perm_checker perm_track = new();

   always #(CLK_PERIOD / 2) clock = ~clock;

   lexicographic_permutation_stepper_top #(
      .DIGITS(N_DIGITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Both handshakes are observed at the rising edge, before the block's own registers
   // move, so the values seen are those the block itself acted upon. The cycle counter
   // ends a run that hangs.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) perm_track.note_request(req_tdata[0]);
      if (!reset && rsp_tvalid && rsp_tready) begin
         perm_track.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d responses outstanding", $time,
                  perm_track.pending());
         $display("FAIL");
         $finish;
      end
   end

   // Response side: ready most of the time, with random stalls, and one long stall on
   // request so that the block backs up and refuses new requests.
   initial begin : response_side
      int unsigned gap;
      forever begin
         @(negedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready = 1'b0;
            repeat (hold_off_cycles - 1) @(negedge clock);
            hold_off_cycles = 0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready = 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Offers one request, perhaps after a random gap, and returns at the rising edge at
   // which it is taken. tvalid stays high into the next call, so back-to-back requests
   // are offered without a break unless that call inserts a random gap.
   task automatic send_request(input bit restart);
      int unsigned gap;
      @(negedge clock);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         gap = $urandom_range(1, 15);
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = REQ_TDATA_W'(restart);
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // Stops offering requests and waits until every predicted response has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (perm_track.pending() != 0) @(posedge clock);
   endtask

   // The target register is only written with the block idle, every response collected.
   task automatic write_target(input bit [RANK_W-1:0] value);
      drain();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      perm_track.target_rank = value;
   endtask

   // A restart followed by a run of plain steps: the well-formed way to walk the order.
   task automatic send_run(input int unsigned steps);
      send_request(1'b1);
      repeat (steps) send_request(1'b0);
   endtask

   // Mostly runs from a restart, a fifth of them long enough for the pivot to move
   // several digits to the left; the remainder is a short spray of random restart bits.
   task automatic random_phase(input int unsigned budget);
      int unsigned sent_here;
      int unsigned run_len;
      sent_here = 0;
      while (sent_here < budget) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 4) == 0) run_len = $urandom_range(WALK_LEN - 50,
                                                                    WALK_LEN + 20);
            else                            run_len = $urandom_range(0, 30);
            send_run(run_len);
            sent_here += run_len + 1;
         end else begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) send_request(1'(($urandom_range(0, 1))));
            sent_here += run_len;
         end
      end
   endtask

   initial begin : stimulus
      int unsigned        phase;
      bit [RANK_W-1:0]    value;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Plain steps straight out of reset with the reset target, then two restarts back to
      // back in the middle of the walk and one more plain step.
      repeat (3) send_request(1'b0);
      send_request(1'b1);
      send_request(1'b1);
      send_request(1'b0);

      // Target at the lowest rank, hit by the restart itself.
      write_target(RANK_W'(1));
      send_request(1'b1);
      send_request(1'b0);

      // Target at the highest legal rank, never reached here.
      write_target(RANK_W'(RANK_TOP));
      repeat (2) send_request(1'b0);

      // Target on the first plain step after a restart.
      write_target(RANK_W'(2));
      send_request(1'b1);
      repeat (2) send_request(1'b0);

      // A long walk from a restart whose last step is flagged as the target.
      write_target(RANK_W'(WALK_LEN + 1));
      send_run(WALK_LEN);

      // Random phases, each with its own target. The third also carries the long stall
      // on the response side; the last runs with no idling on either side.
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       value = RANK_W'($urandom_range(1, WALK_LEN));
            1:       value = RANK_W'(RANK_TOP);
            2:       value = RANK_W'($urandom_range(1, RANK_TOP));
            3:       value = RANK_W'(1);
            default: value = RANK_W'($urandom_range(1, WALK_LEN));
         endcase
         write_target(value);
         req_idle_on = (phase != 4);
         rsp_idle_on = (phase != 4);
         if (phase == 2) hold_off_cycles = 300;
         random_phase(45);
      end

      // Collect the last responses, then watch a while longer for strays.
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (perm_track.errors == 0 && perm_track.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
